>>> sv/aosp_pkg.sv
// ----------------------------------------------------------------------------
// aosp_pkg
// Shared constants, types and helpers of the oversampling ADC block.
// ----------------------------------------------------------------------------
package aosp_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int MAX_OVERSAMPLE = 16;
	localparam int CNT_W          = 5;

	localparam int VREF_MV        = 3300;
	localparam int DIVIDER_RATIO  = 11;
	localparam int ADC_FULL_SCALE = 4096;
	localparam int ADC_SHIFT      = $clog2(ADC_FULL_SCALE);
	localparam int MV_SCALE       = VREF_MV * DIVIDER_RATIO;

	localparam int DIV_BITS = 32;
	localparam int DIV_CW   = $clog2(DIV_BITS + 1);

	localparam logic [1:0] REG_POLL_PERIOD = 2'd0;
	localparam logic [1:0] REG_OVERSAMPLE  = 2'd1;
	localparam logic [1:0] REG_FULL_POWER  = 2'd2;
	localparam logic [1:0] REG_PWM_TOP     = 2'd3;

	localparam logic [15:0]      RST_POLL_PERIOD = 16'd10;
	localparam logic [CNT_W-1:0] RST_OVERSAMPLE  = 5'd8;
	localparam logic [15:0]      RST_FULL_POWER  = 16'd12000;
	localparam logic [15:0]      RST_PWM_TOP     = 16'd1000;

	typedef struct packed {
		logic [15:0]      poll_period_ms;
		logic [CNT_W-1:0] oversample_count;
		logic [15:0]      full_power_mv;
		logic [15:0]      pwm_top;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic poll;          // accepted transaction is a valid poll
		logic emit;          // accepted poll completes a batch
		logic mul;           // form voltage and PWM numerators
		logic div_start_mv;
		logic div_start_pwm;
		logic mv_latch;
		logic pwm_fix;       // clamp: zero or full period
		logic pwm_div;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic poll_ok;
		logic emit;
		logic div_busy;
		logic div_done;
		logic mv_zero;
		logic mv_le_fp;
		logic out_busy;
	} stat_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0)
			r = CNT_W'(1);
		else if (c > CNT_W'(MAX_OVERSAMPLE))
			r = CNT_W'(MAX_OVERSAMPLE);
		return r;
	endfunction

endpackage

>>> sv/aosp_if.sv
// ----------------------------------------------------------------------------
// aosp_in_if / aosp_out_if
// Valid/ready channels for sample polls and oversampled results.
// ----------------------------------------------------------------------------
interface aosp_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic [11:0] sample_vin;
	logic [11:0] sample_left;
	logic [11:0] sample_right;

	modport source (output valid, now_ms, sample_vin, sample_left, sample_right,
		input ready);
	modport sink (input valid, now_ms, sample_vin, sample_left, sample_right,
		output ready);
endinterface

interface aosp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] sum_vin;
	logic [15:0] sum_left;
	logic [15:0] sum_right;
	logic [15:0] supply_mv;
	logic [15:0] pwm_level;

	modport source (output valid, sum_vin, sum_left, sum_right, supply_mv, pwm_level,
		input ready);
	modport sink (input valid, sum_vin, sum_left, sum_right, supply_mv, pwm_level,
		output ready);
endinterface

>>> sv/aosp_div.sv
// ----------------------------------------------------------------------------
// aosp_div
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module aosp_div
	import aosp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [15:0]         divisor,
	output logic [DIV_BITS-1:0] quotient,
	output logic                busy,
	output logic                done
);

	logic [DIV_CW-1:0]   cnt_q;
	logic [15:0]         rem_q;
	logic [15:0]         dvs_q;
	logic [DIV_BITS-1:0] quo_q;
	logic                done_q;

	logic [16:0] trial;
	logic        ge;
	logic [16:0] diff;

	assign trial = {rem_q, quo_q[DIV_BITS-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start)
				cnt_q <= DIV_CW'(DIV_BITS);
			else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == DIV_CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[DIV_BITS-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign busy     = cnt_q != '0;
	assign done     = done_q;

endmodule

>>> sv/aosp_dp.sv
// ----------------------------------------------------------------------------
// aosp_dp
// Datapath: poll timing, accumulators, voltage and PWM arithmetic, result reg.
// ----------------------------------------------------------------------------
module aosp_dp
	import aosp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output stat_t       st,
	input  logic [31:0] now_ms,
	input  logic [11:0] sample_vin,
	input  logic [11:0] sample_left,
	input  logic [11:0] sample_right,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] sum_vin,
	output logic [15:0] sum_left,
	output logic [15:0] sum_right,
	output logic [15:0] supply_mv,
	output logic [15:0] pwm_level
);

	logic [31:0]      last_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      acc_vin_q, acc_left_q, acc_right_q;
	logic [15:0]      sum_vin_q, sum_left_q, sum_right_q;
	logic [CNT_W-1:0] cnt_eff_q;
	logic [31:0]      prod_q;
	logic [31:0]      pf_q;
	logic [15:0]      mv_q;
	logic [15:0]      pwm_q;
	logic             out_valid_q;
	logic [15:0]      o_vin_q, o_left_q, o_right_q, o_mv_q, o_pwm_q;

	logic [31:0]      elapsed;
	logic [15:0]      nxt_vin, nxt_left, nxt_right;
	logic [CNT_W-1:0] nxt_cnt;
	logic [CNT_W-1:0] cnt_eff;

	logic                div_start;
	logic [DIV_BITS-1:0] div_dividend;
	logic [15:0]         div_divisor;
	logic [DIV_BITS-1:0] div_quo;
	logic                div_busy;
	logic                div_done;

	assign elapsed   = now_ms - last_q;
	assign nxt_vin   = acc_vin_q + 16'(sample_vin[SAMPLE_BITS-1:0]);
	assign nxt_left  = acc_left_q + 16'(sample_left[SAMPLE_BITS-1:0]);
	assign nxt_right = acc_right_q + 16'(sample_right[SAMPLE_BITS-1:0]);
	assign nxt_cnt   = cnt_q + CNT_W'(1);
	assign cnt_eff   = eff_count(cfg.oversample_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			cnt_q       <= '0;
			acc_vin_q   <= '0;
			acc_left_q  <= '0;
			acc_right_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.poll) begin
				last_q <= now_ms;
				if (cmd.emit) begin
					cnt_q       <= '0;
					acc_vin_q   <= '0;
					acc_left_q  <= '0;
					acc_right_q <= '0;
				end else begin
					cnt_q       <= nxt_cnt;
					acc_vin_q   <= nxt_vin;
					acc_left_q  <= nxt_left;
					acc_right_q <= nxt_right;
				end
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sum_vin_q   <= nxt_vin;
			sum_left_q  <= nxt_left;
			sum_right_q <= nxt_right;
			cnt_eff_q   <= cnt_eff;
		end
		if (cmd.mul) begin
			prod_q <= 32'(sum_vin_q) * 32'(MV_SCALE);
			pf_q   <= 32'(cfg.pwm_top) * 32'(cfg.full_power_mv);
		end
		if (cmd.mv_latch)
			mv_q <= div_quo[15:0];
		if (cmd.pwm_fix)
			pwm_q <= (mv_q == '0) ? '0 : cfg.pwm_top;
		else if (cmd.pwm_div)
			pwm_q <= div_quo[15:0];
		if (cmd.out_load) begin
			o_vin_q   <= sum_vin_q;
			o_left_q  <= sum_left_q;
			o_right_q <= sum_right_q;
			o_mv_q    <= mv_q;
			o_pwm_q   <= pwm_q;
		end
	end

	// floor(x / 4096 / n) equals floor(x / (4096 * n)), so scale first then divide by n
	assign div_start    = cmd.div_start_mv | cmd.div_start_pwm;
	assign div_dividend = cmd.div_start_mv ? DIV_BITS'(prod_q[31:ADC_SHIFT]) : pf_q;
	assign div_divisor  = cmd.div_start_mv ? 16'(cnt_eff_q) : mv_q;

	aosp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_comb begin
		st.poll_ok  = elapsed >= 32'(cfg.poll_period_ms);
		st.emit     = st.poll_ok && (nxt_cnt >= cnt_eff);
		st.div_busy = div_busy;
		st.div_done = div_done;
		st.mv_zero  = mv_q == '0;
		st.mv_le_fp = mv_q <= cfg.full_power_mv;
		st.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid = out_valid_q;
	assign sum_vin   = o_vin_q;
	assign sum_left  = o_left_q;
	assign sum_right = o_right_q;
	assign supply_mv = o_mv_q;
	assign pwm_level = o_pwm_q;

endmodule

>>> sv/aosp_ctrl.sv
// ----------------------------------------------------------------------------
// aosp_ctrl
// Controller: sequences the multiply, the millivolt division, the PWM division when needed and the result load.
// ----------------------------------------------------------------------------
module aosp_ctrl
	import aosp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_D1S  = 3'd2;
	localparam logic [2:0] S_D1W  = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_D2S  = 3'd5;
	localparam logic [2:0] S_D2W  = 3'd6;
	localparam logic [2:0] S_LOAD = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.poll = st.poll_ok;
					cmd.emit = st.emit;
					if (st.emit)
						state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_D1S;
			end
			S_D1S: begin
				cmd.div_start_mv = 1'b1;
				state_d          = S_D1W;
			end
			S_D1W: begin
				if (st.div_done) begin
					cmd.mv_latch = 1'b1;
					state_d      = S_CHK;
				end
			end
			S_CHK: begin
				if (st.mv_zero || st.mv_le_fp) begin
					cmd.pwm_fix = 1'b1;
					state_d     = S_LOAD;
				end else
					state_d = S_D2S;
			end
			S_D2S: begin
				cmd.div_start_pwm = 1'b1;
				state_d           = S_D2W;
			end
			S_D2W: begin
				if (st.div_done) begin
					cmd.pwm_div = 1'b1;
					state_d     = S_LOAD;
				end
			end
			S_LOAD: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

>>> sv/adc_oversample_supply_pwm_comp.sv
// ----------------------------------------------------------------------------
// adc_oversample_supply_pwm_comp
// Oversampled supply and current ADC sums with supply-compensated PWM level.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  samples  | in  | valid/ready      | now_ms, sample_vin/left/right
//  results  | out | valid/ready      | sum_vin/left/right, supply_mv, pwm_level
//  apb      | in  | psel/penable/... | 4 registers at 4*i, read as 32 bits
//
// A transaction that is not a poll, or a poll that does not complete a batch,
// is taken in the idle state. A batch-completing poll holds samples.ready low
// through the multiply, the divisions and the result load: the shared
// one-bit-a-cycle 32-step divider is used once for millivolts and, unless the
// PWM level is clamped, once for the PWM level. The result register frees the
// input while a result waits; a stalled result blocks only the next batch, which
// then waits in the load state for as long as the stall lasts. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module adc_oversample_supply_pwm_comp
	import aosp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	aosp_in_if.sink     samples,
	aosp_out_if.source  results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t st;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_period_ms   <= RST_POLL_PERIOD;
			cfg_q.oversample_count <= RST_OVERSAMPLE;
			cfg_q.full_power_mv    <= RST_FULL_POWER;
			cfg_q.pwm_top          <= RST_PWM_TOP;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_POLL_PERIOD: cfg_q.poll_period_ms   <= pwdata[15:0];
				REG_OVERSAMPLE:  cfg_q.oversample_count <= pwdata[CNT_W-1:0];
				REG_FULL_POWER:  cfg_q.full_power_mv    <= pwdata[15:0];
				REG_PWM_TOP:     cfg_q.pwm_top          <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_POLL_PERIOD: prdata = 32'(cfg_q.poll_period_ms);
			REG_OVERSAMPLE:  prdata = 32'(cfg_q.oversample_count);
			REG_FULL_POWER:  prdata = 32'(cfg_q.full_power_mv);
			REG_PWM_TOP:     prdata = 32'(cfg_q.pwm_top);
			default:         prdata = '0;
		endcase
	end

	aosp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.st       (st),
		.cmd      (cmd)
	);

	aosp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.st           (st),
		.now_ms       (samples.now_ms),
		.sample_vin   (samples.sample_vin),
		.sample_left  (samples.sample_left),
		.sample_right (samples.sample_right),
		.out_valid    (results.valid),
		.out_ready    (results.ready),
		.sum_vin      (results.sum_vin),
		.sum_left     (results.sum_left),
		.sum_right    (results.sum_right),
		.supply_mv    (results.supply_mv),
		.pwm_level    (results.pwm_level)
	);

	// no new poll is taken while a division is running
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_busy |-> !samples.ready)
		else $error("input ready during division");

	// the result register is never overwritten while a result is stalled
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(results.valid && !results.ready))
		else $error("result overwritten while stalled");

	// zero volts always gives zero drive
	a_zero_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.supply_mv == '0) |-> results.pwm_level == '0)
		else $error("nonzero PWM at zero supply");

	// the millivolt division is only started after the multiply of a batch-completing poll
	a_div_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start_mv |-> $past(cmd.mul))
		else $error("division started without multiply");

endmodule
